### rtl/rtt_pkg.sv
// types, codes and widths shared by the retransmit tracker modules
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

	localparam int SEQ_W   = 16;
	localparam int TICK_W  = 32;
	localparam int SIZE_W  = 11;
	localparam int CNT_W   = 8;
	localparam int KIND_W  = 2;
	localparam int RKIND_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int SIZE_FIELD_MAX = 2047;

	localparam int PENDING_DEPTH_DEF = 32;
	localparam int MAX_PAYLOAD_DEF   = 1024;

	localparam logic [KIND_W-1:0] KIND_QUEUE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COLLECT = 2'd2;

	localparam logic [RKIND_W-1:0] RK_ASSIGNED  = 3'd0;
	localparam logic [RKIND_W-1:0] RK_REJECTED  = 3'd1;
	localparam logic [RKIND_W-1:0] RK_ACK_DONE  = 3'd2;
	localparam logic [RKIND_W-1:0] RK_RESEND    = 3'd3;
	localparam logic [RKIND_W-1:0] RK_SCAN_DONE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_RESEND_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESEND_LIMIT    = 2'd1;

	localparam logic [TICK_W-1:0] RESEND_INTERVAL_RST = 32'd100;
	localparam logic [CNT_W-1:0]  RESEND_LIMIT_RST    = 8'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
		logic [TICK_W-1:0] now_ticks;
		logic [SIZE_W-1:0] payload_size;
	} cmd_t;

	typedef struct packed {
		logic [RKIND_W-1:0] result_kind;
		logic [SEQ_W-1:0]   seq_out;
		logic [SIZE_W-1:0]  size_out;
		logic [CNT_W-1:0]   resend_count;
		logic               ack_found;
		logic               last;
	} res_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic              shift;
		logic              ack_en;
		logic [SEQ_W-1:0]  ack_seq;
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] interval;
		logic [CNT_W-1:0]  resend_limit;
	} cell_ctl_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [TICK_W-1:0] stamp;
		logic [SIZE_W-1:0] size;
	} cell_wr_t;

	typedef struct packed {
		logic              hit;
		logic [SEQ_W-1:0]  seq;
		logic [SIZE_W-1:0] size;
		logic [CNT_W-1:0]  resends;
	} cell_res_t;

endpackage

`default_nettype wire

### rtl/rtt_cell.sv
// one slot of the pending table, with its stage of the scan token chain
`timescale 1ns / 1ps
`default_nettype none

module rtt_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtt_pkg::cell_ctl_t ctl,
	input  wire logic              wr_en,
	input  wire rtt_pkg::cell_wr_t wr,
	input  wire logic              tok_in,
	output logic                   tok,
	output logic                   occupied,
	output logic                   ack_hit,
	output rtt_pkg::cell_res_t     res
);

	logic                         valid_q;
	logic                         tok_q;
	logic [rtt_pkg::SEQ_W-1:0]    seq_q;
	logic [rtt_pkg::TICK_W-1:0]   stamp_q;
	logic [rtt_pkg::CNT_W-1:0]    resends_q;
	logic [rtt_pkg::SIZE_W-1:0]   size_q;

	logic [rtt_pkg::TICK_W-1:0]   elapsed;
	logic                         overdue;
	logic                         at_limit;
	logic                         scan_here;

	always_comb begin
		elapsed   = ctl.now - stamp_q;
		overdue   = valid_q && (elapsed >= ctl.interval);
		at_limit  = resends_q >= ctl.resend_limit;
		scan_here = tok_q && ctl.shift;
		ack_hit   = ctl.ack_en && valid_q && (seq_q == ctl.ack_seq);
		res       = '0;
		if (tok_q && overdue && !at_limit) begin
			res.hit     = 1'b1;
			res.seq     = seq_q;
			res.size    = size_q;
			res.resends = resends_q + 8'd1;
		end
	end

	assign tok      = tok_q;
	assign occupied = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			if (ctl.shift) begin
				tok_q <= tok_in;
			end
			if (wr_en) begin
				valid_q <= 1'b1;
			end else if (ack_hit) begin
				valid_q <= 1'b0;
			end else if (scan_here && overdue && at_limit) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seq_q     <= wr.seq;
			stamp_q   <= wr.stamp;
			resends_q <= '0;
			size_q    <= wr.size;
		end else if (scan_here && res.hit) begin
			resends_q <= res.resends;
			stamp_q   <= ctl.now;
		end
	end

endmodule

`default_nettype wire

### rtl/retransmit_tracker_core.sv
// top level of the retransmit tracker: command decode, slot cells and result register
//
// Commands arrive on cmd (cmd_valid / cmd_stall); a transfer happens on a
// clock edge with cmd_valid high and cmd_stall low. Results leave on res
// (res_valid / res_stall) in the same way. Register writes use cfg_valid,
// cfg_ready, cfg_index and cfg_data; cfg_ready is always high.
// Queue and ack commands give one result, registered in the cycle after the
// command transfer; a new command can transfer in the cycle that result is taken.
// A collect command passes a token down the row of PENDING_DEPTH cells, one
// cell per cycle while no result is stalled, emitting a resend result from each
// overdue cell below the resend limit (an overdue cell at the limit is freed),
// then a scan done result marked last once the token has left the last cell;
// the next command can transfer once that done result is taken.
// While res_stall holds a result, the token and the command side wait.
// Reset clears all slots, the sequence counter and the token, and loads the
// register defaults (interval 100 ticks, 5 resends). Kind 3 is consumed and
// gives no result.
`timescale 1ns / 1ps
`default_nettype none

module retransmit_tracker_core #(
	parameter int PENDING_DEPTH = rtt_pkg::PENDING_DEPTH_DEF,
	parameter int MAX_PAYLOAD   = rtt_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_valid,
	output logic                                  cmd_stall,
	input  wire rtt_pkg::cmd_t                    cmd,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output rtt_pkg::res_t                         res,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rtt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rtt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PTR_W = $clog2(PENDING_DEPTH);
	localparam int SIZE_CAP = (MAX_PAYLOAD < rtt_pkg::SIZE_FIELD_MAX) ?
		MAX_PAYLOAD : rtt_pkg::SIZE_FIELD_MAX;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                        state_q;
	state_t                        state_d;
	logic [rtt_pkg::TICK_W-1:0]    interval_q;
	logic [rtt_pkg::CNT_W-1:0]     resend_limit_q;
	logic [rtt_pkg::SEQ_W-1:0]     next_seq_q;
	logic [PTR_W-1:0]              slot_ptr_q;
	logic [rtt_pkg::TICK_W-1:0]    now_q;
	logic                          res_valid_q;
	logic                          res_valid_d;
	rtt_pkg::res_t                 res_q;
	rtt_pkg::res_t                 res_d;

	logic                          out_free;
	logic                          accept;
	logic                          start_scan;
	logic                          do_queue;
	logic                          slot_busy;
	logic [rtt_pkg::SIZE_W-1:0]    size_sat;

	rtt_pkg::cell_ctl_t            ctl;
	rtt_pkg::cell_wr_t             wr;
	logic [PENDING_DEPTH-1:0]      wr_en;
	logic [PENDING_DEPTH-1:0]      tok_vec;
	logic [PENDING_DEPTH-1:0]      tok_in_vec;
	logic [PENDING_DEPTH-1:0]      occ_vec;
	logic [PENDING_DEPTH-1:0]      ack_vec;
	rtt_pkg::cell_res_t            cell_res [PENDING_DEPTH];
	rtt_pkg::cell_res_t            scan_res;

	assign cfg_ready = 1'b1;
	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = cmd_valid && !cmd_stall;
	assign start_scan = accept && (cmd.kind == rtt_pkg::KIND_COLLECT);
	assign slot_busy = occ_vec[slot_ptr_q];
	assign do_queue  = accept && (cmd.kind == rtt_pkg::KIND_QUEUE) && !slot_busy;
	assign size_sat  = (cmd.payload_size > rtt_pkg::SIZE_W'(SIZE_CAP)) ?
		rtt_pkg::SIZE_W'(SIZE_CAP) : cmd.payload_size;

	always_comb begin
		ctl.shift        = start_scan || ((state_q == ST_SCAN) && out_free);
		ctl.ack_en       = accept && (cmd.kind == rtt_pkg::KIND_ACK);
		ctl.ack_seq      = cmd.seq;
		ctl.now          = now_q;
		ctl.interval     = interval_q;
		ctl.resend_limit = resend_limit_q;
		wr.seq   = next_seq_q;
		wr.stamp = cmd.now_ticks;
		wr.size  = size_sat;
		for (int i = 0; i < PENDING_DEPTH; i++) begin
			wr_en[i] = do_queue && (slot_ptr_q == PTR_W'(i));
		end
		tok_in_vec = {tok_vec[PENDING_DEPTH-2:0], start_scan};
		scan_res = '0;
		for (int i = 0; i < PENDING_DEPTH; i++) begin
			scan_res = scan_res | cell_res[i];
		end
	end

	for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
		rtt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_en    (wr_en[g]),
			.wr       (wr),
			.tok_in   (tok_in_vec[g]),
			.tok      (tok_vec[g]),
			.occupied (occ_vec[g]),
			.ack_hit  (ack_vec[g]),
			.res      (cell_res[g])
		);
	end

	// next state and next result
	always_comb begin
		state_d     = state_q;
		res_valid_d = res_valid_q;
		res_d       = res_q;
		if (out_free) begin
			res_valid_d = 1'b0;
			res_d       = '0;
			unique case (state_q)
				ST_IDLE: begin
					res_d.last = 1'b1;
					if (accept) begin
						unique case (cmd.kind)
							rtt_pkg::KIND_QUEUE: begin
								res_valid_d       = 1'b1;
								res_d.result_kind = slot_busy ?
									rtt_pkg::RK_REJECTED : rtt_pkg::RK_ASSIGNED;
								res_d.seq_out     = next_seq_q;
							end
							rtt_pkg::KIND_ACK: begin
								res_valid_d       = 1'b1;
								res_d.result_kind = rtt_pkg::RK_ACK_DONE;
								res_d.ack_found   = |ack_vec;
							end
							rtt_pkg::KIND_COLLECT: state_d = ST_SCAN;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					res_valid_d        = scan_res.hit;
					res_d.result_kind  = rtt_pkg::RK_RESEND;
					res_d.seq_out      = scan_res.seq;
					res_d.size_out     = scan_res.size;
					res_d.resend_count = scan_res.resends;
					res_d.last         = 1'b0;
					if (tok_vec[PENDING_DEPTH-1]) begin
						state_d = ST_DONE;
					end
				end
				ST_DONE: begin
					res_valid_d       = 1'b1;
					res_d.result_kind = rtt_pkg::RK_SCAN_DONE;
					res_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q     <= rtt_pkg::RESEND_INTERVAL_RST;
			resend_limit_q <= rtt_pkg::RESEND_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rtt_pkg::REG_RESEND_INTERVAL: interval_q <= cfg_data;
				rtt_pkg::REG_RESEND_LIMIT:    resend_limit_q <= cfg_data[rtt_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_seq_q  <= '0;
			slot_ptr_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
			if (do_queue) begin
				next_seq_q <= next_seq_q + 16'd1;
				if ((next_seq_q == '1) || (slot_ptr_q == PTR_W'(PENDING_DEPTH - 1))) begin
					slot_ptr_q <= '0;
				end else begin
					slot_ptr_q <= slot_ptr_q + PTR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			now_q <= cmd.now_ticks;
		end
		res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one scan token in the cell row");

	a_idle_no_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tok_vec == '0))
		else $error("scan token present while idle");

	a_ack_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ack_vec))
		else $error("acknowledge matched more than one slot");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |-> (state_q == ST_IDLE))
		else $error("command transfer during a scan");

	a_resend_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.result_kind == rtt_pkg::RK_RESEND)) |-> !res.last)
		else $error("resend result marked last");
`endif

endmodule

`default_nettype wire

### verif/tracker_checker.sv
// checker for the retransmit tracker: predicts results from observed transfers and compares them
`timescale 1ns / 1ps

module tracker_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  logic                            cmd_stall,
	input  rtt_pkg::cmd_t                   cmd,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  rtt_pkg::res_t                   res,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rtt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              failures,
	output int                              pending,
	output int                              compared
);
	import rtt_pkg::*;

	localparam int DEPTH    = PENDING_DEPTH_DEF;
	localparam int SIZE_CAP = (MAX_PAYLOAD_DEF < SIZE_FIELD_MAX) ? MAX_PAYLOAD_DEF : SIZE_FIELD_MAX;

	logic [TICK_W-1:0] interval;
	logic [CNT_W-1:0]  resend_limit;
	logic [SEQ_W-1:0]  next_seq;
	logic              live [DEPTH];
	logic [SEQ_W-1:0]  slot_seq [DEPTH];
	logic [TICK_W-1:0] stamp [DEPTH];
	logic [CNT_W-1:0]  tries [DEPTH];
	logic [SIZE_W-1:0] bytes [DEPTH];
	res_t              replies [$];
	res_t              want;
	int                fail_count;
	int                seen;

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	task automatic track_command(input cmd_t c);
		res_t r;
		int unsigned slot;
		logic [TICK_W-1:0] elapsed;
		r = '0;
		case (c.kind)
			KIND_QUEUE: begin
				slot = next_seq % DEPTH;
				r.seq_out = next_seq;
				r.last = 1'b1;
				if (live[slot]) begin
					r.result_kind = RK_REJECTED;
				end else begin
					r.result_kind = RK_ASSIGNED;
					live[slot] = 1'b1;
					slot_seq[slot] = next_seq;
					stamp[slot] = c.now_ticks;
					tries[slot] = '0;
					bytes[slot] = (c.payload_size > SIZE_CAP) ? SIZE_W'(SIZE_CAP) : c.payload_size;
					next_seq = next_seq + 1'b1;
				end
				replies = {replies, r};
			end
			KIND_ACK: begin
				slot = c.seq % DEPTH;
				r.result_kind = RK_ACK_DONE;
				r.last = 1'b1;
				if (live[slot] && slot_seq[slot] == c.seq) begin
					live[slot] = 1'b0;
					r.ack_found = 1'b1;
				end
				replies = {replies, r};
			end
			KIND_COLLECT: begin
				for (int s = 0; s < DEPTH; s++) begin
					if (live[s]) begin
						elapsed = c.now_ticks - stamp[s];
						if (elapsed >= interval) begin
							if (tries[s] >= resend_limit) begin
								live[s] = 1'b0;
							end else begin
								tries[s] = tries[s] + 1'b1;
								stamp[s] = c.now_ticks;
								r = '0;
								r.result_kind = RK_RESEND;
								r.seq_out = slot_seq[s];
								r.size_out = bytes[s];
								r.resend_count = tries[s];
								replies = {replies, r};
							end
						end
					end
				end
				r = '0;
				r.result_kind = RK_SCAN_DONE;
				r.last = 1'b1;
				replies = {replies, r};
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval = RESEND_INTERVAL_RST;
			resend_limit = RESEND_LIMIT_RST;
			next_seq = '0;
			for (int s = 0; s < DEPTH; s++) live[s] = 1'b0;
			replies.delete();
			fail_count = 0;
			seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RESEND_INTERVAL: interval = cfg_data;
					REG_RESEND_LIMIT: resend_limit = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				seen++;
				if (replies.size() == 0) begin
					$error("result kind %0d arrived with nothing expected", res.result_kind);
					fail_count++;
				end else begin
					want = replies.pop_front();
					check_field("result_kind", want.result_kind, res.result_kind);
					check_field("seq_out", want.seq_out, res.seq_out);
					check_field("size_out", want.size_out, res.size_out);
					check_field("resend_count", want.resend_count, res.resend_count);
					check_field("ack_found", want.ack_found, res.ack_found);
					check_field("last", want.last, res.last);
				end
			end
			if (cmd_valid && !cmd_stall) track_command(cmd);
		end
		failures <= fail_count;
		pending <= replies.size();
		compared <= seen;
	end

endmodule

### verif/tb.sv
// testbench top for the retransmit tracker: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
	import rtt_pkg::*;

	localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int DRAIN_CYCLES = PENDING_DEPTH_DEF + 8;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 54;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_stall;
	cmd_t                  cmd;
	logic                  res_valid;
	logic                  res_stall;
	res_t                  res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    failures;
	int                    pending;
	int                    compared;
	bit                    idle_on;
	int                    quiet_cycles;
	logic [TICK_W-1:0]     tick_now;
	logic [TICK_W-1:0]     interval_now;
	logic [SEQ_W-1:0]      approx_next;
	int                    kind_count [4];
	int                    reg_writes;

	retransmit_tracker_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tracker_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending),
		.compared  (compared)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls in bursts
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic cmd_t make_cmd(input logic [KIND_W-1:0] k, input logic [SEQ_W-1:0] sq,
			input logic [TICK_W-1:0] t, input logic [SIZE_W-1:0] sz);
		cmd_t c;
		c.kind = k;
		c.seq = sq;
		c.now_ticks = t;
		c.payload_size = sz;
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		kind_count[c.kind]++;
		if (c.kind == KIND_QUEUE) approx_next = approx_next + 1'b1;
	endtask

	task automatic quiesce();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// leaves cfg_valid high so that writes can follow back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_writes++;
	endtask

	task automatic set_timing(input logic [TICK_W-1:0] ivl, input logic [CNT_W-1:0] lim,
			input bit spare);
		logic [CFG_DATA_W-1:0] junk;
		junk = $urandom();
		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (spare) begin
			write_reg(REG_SPARE_LO, $urandom());
			write_reg(REG_SPARE_HI, $urandom());
		end
		write_reg(REG_RESEND_INTERVAL, ivl);
		write_reg(REG_RESEND_LIMIT, {junk[CFG_DATA_W-1:CNT_W], lim});
		cfg_valid <= 1'b0;
		interval_now = ivl;
	endtask

	task automatic random_item(input int q_share, input int a_share);
		cmd_t c;
		int roll;
		int unsigned step;
		c.seq = SEQ_W'($urandom());
		c.now_ticks = $urandom();
		c.payload_size = SIZE_W'($urandom());
		step = (interval_now > 300) ? 300 : interval_now;
		if ($urandom_range(0, 39) == 0)
			tick_now = $urandom();
		else
			tick_now = tick_now + $urandom_range(0, step / 2 + 1);
		roll = $urandom_range(0, 99);
		if (roll < q_share) begin
			c.kind = KIND_QUEUE;
			c.now_ticks = tick_now;
			if ($urandom_range(0, 7) != 0)
				c.payload_size = SIZE_W'($urandom_range(1, MAX_PAYLOAD_DEF));
		end else if (roll < q_share + a_share) begin
			c.kind = KIND_ACK;
			if ($urandom_range(0, 4) != 0)
				c.seq = SEQ_W'(approx_next - $urandom_range(1, 40));
		end else if (roll == 99) begin
			c.kind = KIND_UNUSED;
		end else begin
			c.kind = KIND_COLLECT;
			c.now_ticks = tick_now;
		end
		if ($urandom_range(0, 49) == 0) quiesce();
		send_cmd(c);
	endtask

	initial begin
		logic [TICK_W-1:0] base;
		int q_share;
		int a_share;
		idle_on = 1'b1;
		tick_now = '0;
		interval_now = RESEND_INTERVAL_RST;
		approx_next = '0;
		reg_writes = 0;
		for (int k = 0; k < 4; k++) kind_count[k] = 0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: interval 100, five resends
		send_cmd(make_cmd(KIND_QUEUE, 16'hFFFF, 32'd0, 11'd1));
		send_cmd(make_cmd(KIND_QUEUE, 16'h0000, 32'd0, 11'd1024));
		send_cmd(make_cmd(KIND_QUEUE, 16'h5555, 32'd10, 11'd2047));
		send_cmd(make_cmd(KIND_QUEUE, 16'hAAAA, 32'd20, 11'd0));
		send_cmd(make_cmd(KIND_ACK, 16'd1, 32'hFFFF_FFFF, 11'h7FF));
		send_cmd(make_cmd(KIND_ACK, 16'd1, 32'd0, 11'd0));
		send_cmd(make_cmd(KIND_ACK, 16'd32, 32'd0, 11'd0));
		send_cmd(make_cmd(KIND_ACK, 16'hFFFF, 32'd0, 11'd0));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'd50, 11'd0));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'd100, 11'd0));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'd120, 11'd0));
		send_cmd(make_cmd(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 11'h7FF));
		send_cmd(make_cmd(KIND_ACK, 16'd0, 32'd0, 11'd0));

		// zero interval: everything overdue, one resend allowed
		set_timing(32'd0, 8'd1, 1'b1);
		send_cmd(make_cmd(KIND_QUEUE, 16'd0, 32'd200, 11'd7));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'd200, 11'd0));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'd200, 11'd0));

		// widest interval, reached only through tick wrap
		set_timing(32'hFFFF_FFFF, 8'd255, 1'b0);
		send_cmd(make_cmd(KIND_QUEUE, 16'd0, 32'hFFFF_FFF0, 11'd512));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'hFFFF_FFEE, 11'd0));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'hFFFF_FFEF, 11'd0));
		send_cmd(make_cmd(KIND_ACK, 16'd5, 32'd0, 11'd0));

		// no resends allowed: overdue entries vanish
		set_timing(32'd1, 8'd0, 1'b0);
		send_cmd(make_cmd(KIND_QUEUE, 16'd0, 32'd0, 11'd3));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'd0, 11'd0));
		send_cmd(make_cmd(KIND_COLLECT, 16'd0, 32'd1, 11'd0));
		send_cmd(make_cmd(KIND_ACK, 16'd6, 32'd0, 11'd0));

		// fill the table, then drop every entry in one scan
		idle_on = 1'b0;
		base = $urandom();
		repeat (PENDING_DEPTH_DEF)
			send_cmd(make_cmd(KIND_QUEUE, SEQ_W'($urandom()), base, SIZE_W'($urandom())));
		send_cmd(make_cmd(KIND_COLLECT, SEQ_W'($urandom()), base + 1'b1, SIZE_W'($urandom())));

		tick_now = $urandom();
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					set_timing(32'($urandom_range(20, 200)), 8'($urandom_range(1, 4)), 1'b0);
					q_share = 45;
					a_share = 30;
				end
				1: begin
					set_timing(32'd1, 8'd255, 1'b0);
					q_share = 60;
					a_share = 12;
				end
				2: begin
					set_timing(32'hFFFF_FFFF, 8'($urandom_range(0, 255)), 1'b0);
					q_share = 45;
					a_share = 25;
				end
				3: begin
					set_timing(32'($urandom_range(1, 300)), 8'd0, 1'b0);
					q_share = 40;
					a_share = 30;
				end
				default: begin
					set_timing(32'($urandom_range(1, 1000)), 8'($urandom_range(0, 255)), 1'b0);
					q_share = 45;
					a_share = 30;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				idle_on = (p < PHASES - 1) && ((i / 16) % 4 != 3);
				random_item(q_share, a_share);
			end
		end

		idle_on = 1'b0;
		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("run covered %0d queue, %0d ack, %0d collect and %0d unused commands, %0d reg writes",
			kind_count[KIND_QUEUE], kind_count[KIND_ACK], kind_count[KIND_COLLECT],
			kind_count[KIND_UNUSED], reg_writes);
		$display("%0d results compared, table filled and flushed once", compared);
		if (failures == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/rtt_pkg.sv
rtl/rtt_cell.sv
rtl/retransmit_tracker_core.sv
verif/tracker_checker.sv
verif/tb.sv
